// ----- sv/timed_event_slot_scheduler_unit_assert.svh -----
// Assertion macros for the timed event slot scheduler.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef TIMED_EVENT_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define TIMED_EVENT_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TESS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");
`define TESS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define TESS_ASSERT_SAME(label, ante, cons)
`define TESS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/tess_pkg.sv -----
`default_nettype none
package tess_pkg;

  // Command codes of the input beat.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CHANGE = 2'd1;
  localparam logic [1:0] CMD_SELECT = 2'd2;
  localparam logic [1:0] CMD_RETIRE = 2'd3;

  // Slot indexes travel at the widest size the table may take.
  localparam int MAX_IDX_W = 8;

  // Update request for the active and current flag vectors.
  typedef struct packed {
    logic                 set_act;  // slot becomes active, not current
    logic                 clr_act;  // slot becomes free
    logic                 clr_cur;  // slot is no longer current
    logic                 sel_cur;  // slot becomes the only current one
    logic [MAX_IDX_W-1:0] idx;
  } tess_flag_op_t;

endpackage
`default_nettype wire

// ----- sv/tess_due_mem.sv -----
`default_nettype none
module tess_due_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- sv/tess_flags.sv -----
`default_nettype none
module tess_flags
  import tess_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tess_flag_op_t        op,
  output logic      [NUM_SLOTS-1:0] act_vec,
  output logic      [NUM_SLOTS-1:0] cur_vec
);

  localparam int SW = $clog2(NUM_SLOTS);

  logic [NUM_SLOTS-1:0] act_r, act_nxt;
  logic [NUM_SLOTS-1:0] cur_r, cur_nxt;
  logic [SW-1:0]        idx;

  assign idx = SW'(op.idx);

  always_comb begin
    act_nxt = act_r;
    cur_nxt = cur_r;
    if (op.set_act) begin
      act_nxt[idx] = 1'b1;
      cur_nxt[idx] = 1'b0;
    end
    if (op.clr_act) begin
      act_nxt[idx] = 1'b0;
    end
    if (op.clr_cur) begin
      cur_nxt[idx] = 1'b0;
    end
    if (op.sel_cur) begin
      cur_nxt      = '0;
      cur_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      cur_r <= '0;
    end else begin
      act_r <= act_nxt;
      cur_r <= cur_nxt;
    end
  end

  assign act_vec = act_r;
  assign cur_vec = cur_r;

endmodule
`default_nettype wire

// ----- sv/timed_event_slot_scheduler_unit.sv -----
// Change writes its due time from idle; retire reads a valid slot and writes it in ST_RET;
// add walks the active flags up to the lowest free slot, or reports a full table; select
// walks the due-time memory past the single comparator one entry per cycle, then checks the limit.
// One command at a time; the next may be accepted in the cycle its predecessor's result shows.
// The receiver cannot stall. Synchronous active-low reset clears the sequencer and all flags;
// the due-time memory is not cleared.
`default_nettype none
`include "timed_event_slot_scheduler_unit_assert.svh"
module timed_event_slot_scheduler_unit
  import tess_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_WIDTH = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [3:0]  in_slot,
  input  wire logic [47:0] in_time_value,
  input  wire logic [31:0] in_repeat_amount,
  output logic             out_valid,
  output logic [3:0]       out_slot_out,
  output logic             out_found,
  output logic [47:0]      out_due_time,
  output logic             out_table_full,
  output logic             out_end_timeslice
);

  localparam int SW   = $clog2(NUM_SLOTS);
  localparam int TW   = TIME_WIDTH;
  // The retire sum must hold a full due time plus a 32-bit repeat without wrapping.
  localparam int SUMW = ((TW > 32) ? TW : 32) + 1;

  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [TW-1:0] TIME_MAX  = '1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a command beat
  localparam logic [2:0] ST_ADD  = 3'd1;  // walking the active flags for a free slot
  localparam logic [2:0] ST_SEL  = 3'd2;  // streaming due times past the comparator
  localparam logic [2:0] ST_SFIN = 3'd3;  // checking the winner against the limit
  localparam logic [2:0] ST_RET  = 3'd4;  // read-modify-write of the retired slot

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          have_r, have_nxt;
  logic [SW-1:0] best_idx_r, best_idx_nxt;
  logic [TW-1:0] best_due_r, best_due_nxt;
  logic [TW-1:0] tv_r, tv_nxt;
  logic [31:0]   rep_r, rep_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_slot_r, out_slot_nxt;
  logic          out_found_r, out_found_nxt;
  logic [47:0]   out_due_r, out_due_nxt;
  logic          out_full_r, out_full_nxt;
  logic          out_end_r, out_end_nxt;

  logic          mem_wr_en;
  logic [SW-1:0] mem_wr_addr;
  logic [TW-1:0] mem_wr_data;
  logic [SW-1:0] mem_rd_addr;
  logic [TW-1:0] mem_rd_data;

  tess_flag_op_t        flag_op;
  logic [NUM_SLOTS-1:0] act_vec;
  logic [NUM_SLOTS-1:0] cur_vec;

  logic          in_slot_ok;
  logic [SW-1:0] in_idx;
  logic [SUMW-1:0] ret_sum;
  logic [TW-1:0]   ret_due;

  // Due times live in a single-port-read memory with a registered read. Only one
  // command is in flight and every write lands on the edge that ends a command, so a read
  // can never meet a write to the same entry: the sequencer itself is the interlock.
  tess_due_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (TW)
  ) u_due_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Active and current bits sit in flip-flops so that reset clears them at once.
  tess_flags #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (flag_op),
    .act_vec (act_vec),
    .cur_vec (cur_vec)
  );

  assign busy       = (state_r != ST_IDLE);
  assign in_slot_ok = (32'(in_slot) < NUM_SLOTS);
  assign in_idx     = SW'(in_slot);

  // Retire advances the due time and saturates at the largest representable time.
  assign ret_sum = SUMW'(mem_rd_data) + SUMW'(rep_r);
  assign ret_due = (ret_sum > SUMW'(TIME_MAX)) ? TIME_MAX : TW'(ret_sum);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    have_nxt     = have_r;
    best_idx_nxt = best_idx_r;
    best_due_nxt = best_due_r;
    tv_nxt       = tv_r;
    rep_nxt      = rep_r;
    slot_nxt     = slot_r;

    // Result fields are all zero unless a command fills them in.
    out_valid_nxt = 1'b0;
    out_slot_nxt  = '0;
    out_found_nxt = 1'b0;
    out_due_nxt   = '0;
    out_full_nxt  = 1'b0;
    out_end_nxt   = 1'b0;

    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    mem_rd_addr = '0;
    flag_op     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          tv_nxt   = TW'(in_time_value);
          rep_nxt  = in_repeat_amount;
          slot_nxt = in_idx;
          idx_nxt  = '0;
          have_nxt = 1'b0;
          case (in_command)
            CMD_ADD: begin
              state_nxt = ST_ADD;
            end
            CMD_CHANGE: begin
              // Change needs no read: write the new due time and report whether the
              // slot was the one currently running.
              out_valid_nxt = 1'b1;
              if (in_slot_ok) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = in_idx;
                mem_wr_data = TW'(in_time_value);
                out_end_nxt = cur_vec[in_idx];
              end
            end
            CMD_SELECT: begin
              mem_rd_addr = '0;
              state_nxt   = ST_SEL;
            end
            CMD_RETIRE: begin
              if (in_slot_ok) begin
                mem_rd_addr = in_idx;
                state_nxt   = ST_RET;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_ADD: begin
        if (!act_vec[idx_r]) begin
          mem_wr_en       = 1'b1;
          mem_wr_addr     = idx_r;
          mem_wr_data     = tv_r;
          flag_op.set_act = 1'b1;
          flag_op.idx     = MAX_IDX_W'(idx_r);
          out_valid_nxt   = 1'b1;
          out_slot_nxt    = 4'(idx_r);
          out_found_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (idx_r == LAST_SLOT) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_SEL: begin
        // The read data belongs to idx_r; the next entry is requested meanwhile.
        mem_rd_addr = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;
        if (act_vec[idx_r] && (!have_r || (mem_rd_data < best_due_r))) begin
          have_nxt     = 1'b1;
          best_idx_nxt = idx_r;
          best_due_nxt = mem_rd_data;
        end
        if (idx_r == LAST_SLOT) begin
          state_nxt = ST_SFIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_SFIN: begin
        out_valid_nxt = 1'b1;
        if (have_r && (best_due_r < tv_r)) begin
          flag_op.sel_cur = 1'b1;
          flag_op.idx     = MAX_IDX_W'(best_idx_r);
          out_slot_nxt    = 4'(best_idx_r);
          out_found_nxt   = 1'b1;
          out_due_nxt     = 48'(best_due_r);
        end
        state_nxt = ST_IDLE;
      end

      ST_RET: begin
        flag_op.clr_cur = 1'b1;
        flag_op.idx     = MAX_IDX_W'(slot_r);
        if (rep_r == '0) begin
          flag_op.clr_act = 1'b1;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = slot_r;
          mem_wr_data = ret_due;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_due_r <= best_due_nxt;
    tv_r       <= tv_nxt;
    rep_r      <= rep_nxt;
    slot_r     <= slot_nxt;
    out_slot_r  <= out_slot_nxt;
    out_found_r <= out_found_nxt;
    out_due_r   <= out_due_nxt;
    out_full_r  <= out_full_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_slot_out      = out_slot_r;
  assign out_found         = out_found_r;
  assign out_due_time      = out_due_r;
  assign out_table_full    = out_full_r;
  assign out_end_timeslice = out_end_r;

  // At most one slot is ever marked current.
  `TESS_ASSERT_SAME(a_cur_onehot0, 1'b1, $onehot0(cur_vec))
  // A current slot is always an active one.
  `TESS_ASSERT_SAME(a_cur_active, 1'b1, (cur_vec & ~act_vec) == '0)
  // Every accepted command either shows its result in the next cycle or keeps the unit busy.
  `TESS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid)
  // The limit check always ends in a result beat.
  `TESS_ASSERT_NEXT(a_sfin_result, state_r == ST_SFIN, out_valid && !busy)
  // A result beat never reports success and a full table together.
  `TESS_ASSERT_SAME(a_found_full, out_valid, !(out_found && out_table_full))

endmodule
`default_nettype wire

// ----- dv/tess_result_checker.sv -----
module tess_result_checker
  import tess_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_WIDTH = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [3:0]  in_slot,
  input  wire logic [47:0] in_time_value,
  input  wire logic [31:0] in_repeat_amount,
  input  wire logic        out_valid,
  input  wire logic [3:0]  out_slot_out,
  input  wire logic        out_found,
  input  wire logic [47:0] out_due_time,
  input  wire logic        out_table_full,
  input  wire logic        out_end_timeslice,
  output int               fail_count,
  output int               pending_beats
);

  localparam logic [47:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  typedef struct packed {
    logic [3:0]  slot_out;
    logic        found;
    logic [47:0] due_time;
    logic        table_full;
    logic        end_timeslice;
  } sched_result_t;

  logic [47:0]          due_tab [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] active_vec;
  logic [NUM_SLOTS-1:0] current_vec;
  sched_result_t        expected_results[$];

  // Applies one command to the shadow slot table and returns the result it must give.
  function automatic sched_result_t predict_sched_result(input logic [1:0]  cmd,
                                                         input logic [3:0]  sl,
                                                         input logic [47:0] tv,
                                                         input logic [31:0] rep);
    sched_result_t res;
    logic [48:0]   advanced;
    int            best;
    res  = '0;
    best = -1;
    case (cmd)
      CMD_ADD: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (best < 0 && !active_vec[i]) best = i;
        end
        if (best < 0) begin
          res.table_full = 1'b1;
        end else begin
          due_tab[best]     = tv;
          active_vec[best]  = 1'b1;
          current_vec[best] = 1'b0;
          res.slot_out      = 4'(best);
          res.found         = 1'b1;
        end
      end
      CMD_CHANGE: begin
        if (sl < NUM_SLOTS) begin
          due_tab[sl]       = tv;
          res.end_timeslice = current_vec[sl];
        end
      end
      CMD_SELECT: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (active_vec[i] && (best < 0 || due_tab[i] < due_tab[best])) best = i;
        end
        if (best >= 0 && due_tab[best] < tv) begin
          current_vec       = '0;
          current_vec[best] = 1'b1;
          res.slot_out      = 4'(best);
          res.found         = 1'b1;
          res.due_time      = due_tab[best];
        end
      end
      CMD_RETIRE: begin
        if (sl < NUM_SLOTS) begin
          current_vec[sl] = 1'b0;
          if (rep == '0) begin
            active_vec[sl] = 1'b0;
          end else begin
            advanced    = {1'b0, due_tab[sl]} + {17'd0, rep};
            due_tab[sl] = advanced[48] ? TIME_MAX : advanced[47:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int field_mismatch(input string       name,
                                        input logic [47:0] want,
                                        input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // The result beat is compared before a new command is predicted, so a beat and an
  // acceptance on the same edge are handled in the right order.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      active_vec  = '0;
      current_vec = '0;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("Result beat arrived with no command outstanding.");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          fail_count += field_mismatch("slot_out", 48'(want.slot_out), 48'(out_slot_out));
          fail_count += field_mismatch("found", 48'(want.found), 48'(out_found));
          fail_count += field_mismatch("due_time", want.due_time, out_due_time);
          fail_count += field_mismatch("table_full", 48'(want.table_full),
                                       48'(out_table_full));
          fail_count += field_mismatch("end_timeslice", 48'(want.end_timeslice),
                                       48'(out_end_timeslice));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_sched_result(in_command, in_slot,
                                                        in_time_value, in_repeat_amount));
      end
    end
    pending_beats <= expected_results.size();
  end

endmodule

// ----- dv/tb_timed_event_slot_scheduler_unit.sv -----
module tb_timed_event_slot_scheduler_unit;
  import tess_pkg::*;

  localparam int          NUM_SLOTS      = 16;
  localparam int          TIME_WIDTH     = 48;
  localparam logic [47:0] TIME_MAX       = {TIME_WIDTH{1'b1}};
  localparam int          ITEM_TARGET    = 1900;
  // A select is the longest command and the longest sender gap is far shorter than this, so a
  // silence of this length can only mean the block has hung.
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = NUM_SLOTS + 4;

  // Every input is given a known value from time zero.
  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic [1:0]  in_command       = CMD_ADD;
  logic [3:0]  in_slot          = '0;
  logic [47:0] in_time_value    = '0;
  logic [31:0] in_repeat_amount = '0;
  logic        busy;
  logic        out_valid;
  logic [3:0]  out_slot_out;
  logic        out_found;
  logic [47:0] out_due_time;
  logic        out_table_full;
  logic        out_end_timeslice;

  int          fail_count;
  int          pending_beats;

  // Bookkeeping for the summary and for sequences that act on a select's outcome.
  int          n_sent = 0;
  int          cmd_count [4] = '{default: 0};
  int          n_results = 0;
  int          n_full = 0;
  int          n_fired = 0;
  logic [3:0]  last_slot = '0;
  logic        last_found = 1'b0;
  logic [47:0] time_base = '0;
  int          idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  timed_event_slot_scheduler_unit #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_slot           (in_slot),
    .in_time_value     (in_time_value),
    .in_repeat_amount  (in_repeat_amount),
    .out_valid         (out_valid),
    .out_slot_out      (out_slot_out),
    .out_found         (out_found),
    .out_due_time      (out_due_time),
    .out_table_full    (out_table_full),
    .out_end_timeslice (out_end_timeslice)
  );

  tess_result_checker #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_slot           (in_slot),
    .in_time_value     (in_time_value),
    .in_repeat_amount  (in_repeat_amount),
    .out_valid         (out_valid),
    .out_slot_out      (out_slot_out),
    .out_found         (out_found),
    .out_due_time      (out_due_time),
    .out_table_full    (out_table_full),
    .out_end_timeslice (out_end_timeslice),
    .fail_count        (fail_count),
    .pending_beats     (pending_beats)
  );

  // The last result beat is latched so that a sequence can act on the slot that a
  // select has just chosen, once it has waited for that beat.
  always @(posedge clk) begin
    if (out_valid) begin
      n_results  <= n_results + 1;
      last_slot  <= out_slot_out;
      last_found <= out_found;
      if (out_table_full) n_full <= n_full + 1;
    end
  end

  // The watchdog counts cycles in which neither a command nor a result beat moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("No beat has moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Presents a command and holds it until the block takes it. Start is left high, so a
  // following command may go straight out on the accepting edge.
  task automatic send_cmd(input logic [1:0]  cmd,
                          input logic [3:0]  sl,
                          input logic [47:0] tv,
                          input logic [31:0] rep);
    in_command       <= cmd;
    in_slot          <= sl;
    in_time_value    <= tv;
    in_repeat_amount <= rep;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    n_sent++;
    cmd_count[cmd]++;
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds the sender back until every outstanding result beat has come. The first edge
  // is always waited for, since the checker's count is registered and lags the accepting edge.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  // Mostly back-to-back or short gaps, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Due times cluster round a moving base, so that ties and near misses against a
  // select limit are common, with the extremes and wholly random values mixed in.
  function automatic logic [47:0] rand_time();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return TIME_MAX - 48'($urandom_range(0, 40));
      3, 4:    return 48'({$urandom, $urandom});
      default: return time_base + 48'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [31:0] rand_repeat();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return '1;
      4, 5:    return 32'($urandom);
      default: return 32'($urandom_range(1, 100));
    endcase
  endfunction

  initial begin
    int choice;
    int burst_len;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------------------------------------------------------------------------
    // Directed part. It walks through the corner cases in order and, by filling the
    // table, leaves every due-time entry written, so nothing later can read an entry
    // that was never set.
    // ---------------------------------------------------------------------------------
    send_cmd(CMD_SELECT, 4'd0, TIME_MAX, '0);       // empty table: nothing is due
    send_cmd(CMD_ADD, 4'd0, '0, '0);                // slot 0 due at zero
    send_cmd(CMD_ADD, 4'd9, TIME_MAX, '0);          // slot 1 due at the largest time
    send_cmd(CMD_SELECT, 4'd0, '0, '0);             // earliest is not below a zero limit
    send_cmd(CMD_SELECT, 4'd0, 48'd1, '0);          // slot 0 fires and becomes current
    send_cmd(CMD_CHANGE, 4'd0, 48'd5, '0);          // change of the current slot
    wait_drained();
    send_cmd(CMD_RETIRE, 4'd0, '0, '0);             // free slot 0 and drop current
    send_cmd(CMD_CHANGE, 4'd0, 48'd7, '0);          // change of an inactive slot
    send_cmd(CMD_SELECT, 4'd0, TIME_MAX, '0);       // largest due time against largest limit
    send_cmd(CMD_RETIRE, 4'd1, '0, 32'd1);          // advance saturates at the largest time
    idle_for(pick_gap());
    // Fill the table; the first few adds share a due time so that a select must break
    // the tie on the lowest index, and the final add finds the table full.
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_cmd(CMD_ADD, 4'($urandom), (i < 4) ? 48'd3 : rand_time(), 32'($urandom));
    end
    send_cmd(CMD_ADD, 4'd0, 48'd3, '0);
    send_cmd(CMD_SELECT, 4'd0, 48'd4, '0);
    send_cmd(CMD_RETIRE, 4'd0, '0, '1);             // largest repeat amount
    wait_drained();

    // ---------------------------------------------------------------------------------
    // Random part. Half of it is the add, select, then retire or change of the fired
    // slot that a real scheduler goes through; the rest is noise, gapless bursts, table
    // fills and mass frees.
    // ---------------------------------------------------------------------------------
    while (n_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0:       time_base = '0;
          1:       time_base = TIME_MAX - 48'd200;
          default: time_base = 48'({$urandom, $urandom});
        endcase
      end
      choice = $urandom_range(0, 9);
      case (choice)
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(0, 2)) begin
            send_cmd(CMD_ADD, 4'($urandom), rand_time(), 32'($urandom));
            idle_for(pick_gap());
          end
          send_cmd(CMD_SELECT, 4'($urandom), rand_time(), 32'($urandom));
          // The sender pauses here until the select's beat has come back.
          wait_drained();
          if (last_found) begin
            n_fired++;
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: send_cmd(CMD_RETIRE, last_slot, rand_time(), '0);
              5, 6, 7:       send_cmd(CMD_RETIRE, last_slot, rand_time(), rand_repeat());
              default: begin
                send_cmd(CMD_CHANGE, last_slot, rand_time(), 32'($urandom));
                if ($urandom_range(0, 1) == 1) begin
                  send_cmd(CMD_RETIRE, last_slot, rand_time(), rand_repeat());
                end
              end
            endcase
          end
          idle_for(pick_gap());
        end
        5, 6: begin
          send_cmd(2'($urandom), 4'($urandom), rand_time(), rand_repeat());
          idle_for(pick_gap());
        end
        7: begin
          burst_len = $urandom_range(5, 30);
          repeat (burst_len) begin
            send_cmd(2'($urandom), 4'($urandom), rand_time(), rand_repeat());
          end
          idle_for(pick_gap());
        end
        8: begin
          repeat ($urandom_range(4, NUM_SLOTS + 2)) begin
            send_cmd(CMD_ADD, 4'($urandom), rand_time(), 32'($urandom));
          end
          idle_for(pick_gap());
        end
        default: begin
          repeat ($urandom_range(2, 10)) begin
            send_cmd(CMD_RETIRE, 4'($urandom), rand_time(), '0);
            idle_for(pick_gap());
          end
        end
      endcase
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_beats != 0) begin
      $error("%0d expected result beats never arrived.", pending_beats);
    end

    $display("Drove %0d commands: %0d add, %0d change, %0d select, %0d retire.",
             n_sent, cmd_count[CMD_ADD], cmd_count[CMD_CHANGE], cmd_count[CMD_SELECT],
             cmd_count[CMD_RETIRE]);
    $display("Checked %0d result beats; %0d selects fired, %0d adds met a full table.",
             n_results, n_fired, n_full);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
